// File: rtl/assert_macros.svh
// Assertion macros shared by the color fader RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define MCF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define MCF_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MCF_ASSERT(name, clk, rst_n, prop)
`define MCF_NEVER(name, clk, rst_n, cond)
`endif
`endif

// File: rtl/mcf_pkg.sv
// Types and constants of the multi-channel color fader.
// No dependencies; imported by multi_channel_color_fader.
package mcf_pkg;

  localparam int unsigned FaderCount = 8;
  localparam int unsigned TimeBits   = 16;
  localparam int unsigned IdxW       = (FaderCount > 1) ? $clog2(FaderCount) : 1;
  localparam int unsigned GroupW     = 3;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumW       = ChanW + TimeBits;
  localparam int unsigned TicketW    = 16;

  localparam logic [TimeBits-1:0] TimeMax   = '1;
  localparam logic [31:0]         ColorReset = 32'hFF00_0000;

  typedef enum logic [2:0] {
    CmdTick    = 3'd0,
    CmdFadeIn  = 3'd1,
    CmdFadeOut = 3'd2,
    CmdStop    = 3'd3,
    CmdQuery   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StPrep,
    StDiv,
    StFin
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  group;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] fade_ticks;
    logic        use_current;
    logic [15:0] elapsed_step;
    logic [15:0] query_ticket;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  fader_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        is_active;
    logic        is_playing;
    logic [15:0] new_ticket;
    logic        last;
  } out_beat_t;

  // One memory word holds a whole fader. Colors keep red in the low byte.
  typedef struct packed {
    logic [31:0]         start_color;
    logic [31:0]         target_color;
    logic [31:0]         drawn_color;
    logic [TimeBits-1:0] fade_length;
    logic [TimeBits-1:0] time_spent;
    logic                fading_in;
    logic [TicketW-1:0]  fade_ticket;
    logic                active_flag;
  } fader_t;

  localparam fader_t FaderReset = '{
    start_color:  ColorReset,
    target_color: ColorReset,
    drawn_color:  ColorReset,
    fade_length:  '0,
    time_spent:   '0,
    fading_in:    1'b0,
    fade_ticket:  '0,
    active_flag:  1'b0
  };

  // One restoring divider lane: partial remainder and the shifting
  // numerator bits that turn into quotient bits.
  typedef struct packed {
    logic [TimeBits-1:0] rem;
    logic [ChanW-1:0]    qn;
  } div_lane_t;

  // Sequencer strobes toward the datapath.
  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic lane_init;
    logic lane_step;
    logic fin_go;
  } ctrl_t;

endpackage

// File: rtl/multi_channel_color_fader.sv
// Top level of the multi-channel color fader: sequencer, fader memory,
// four-lane serial divider and output register. Depends on mcf_pkg and
// assert_macros.svh.
//
//  channel | direction | beat type          | handshake
//  --------+-----------+--------------------+---------------------------
//  in      | input     | mcf_pkg::in_beat_t  | in_valid_i / in_ready_o
//  out     | output    | mcf_pkg::out_beat_t | out_valid_o / out_ready_i
//
// Each addressed fader passes through one memory read, one state that forms
// the four blend numerators, eight steps of the one-bit-per-cycle divider
// lanes and one write-back state; an out-of-range group goes straight to
// write-back. A tick walks all FaderCount faders in turn; fade, stop and
// query address one fader, and an unknown command is taken and dropped with
// no result beat. A beat is taken only in idle, so one command finishes
// before the next is taken; after an unknown command the next beat can be
// taken on the next cycle. The shared divider and the single memory port
// handle the faders one at a time. After reset every fader reads as its
// reset value through per-entry valid bits, with no clearing pass. The
// write-back cycle waits while the output register still holds an untaken
// beat; a new input beat is taken once the sequencer is idle, even while
// the last result still waits in the output register.
`include "assert_macros.svh"

module multi_channel_color_fader (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mcf_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcf_pkg::out_beat_t  out_data_o
);
  import mcf_pkg::*;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(FaderCount - 1);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  in_beat_t          cur_q;
  logic              oor_q;
  logic [IdxW-1:0]   idx_q;
  logic [2:0]        cnt_q;
  logic [FaderCount-1:0] vld_q;

  // The fader memory: one word per fader, synchronous read.
  fader_t mem_q [FaderCount];
  fader_t rd_q;
  logic   rd_vld_q;
  fader_t ent;

  div_lane_t lane_q [4];
  logic      bypass_q;

  out_beat_t out_q, res;
  logic      out_valid_q;
  logic      out_free;
  logic      mem_we;
  fader_t    wr_ent;

  logic in_oor;
  logic is_tick;
  logic tick_more;

  assign in_oor = ({1'b0, in_data_i.group} >= (GroupW + 1)'(FaderCount));
  assign is_tick = (cur_q.cmd == CmdTick);
  assign tick_more = is_tick && (idx_q != IdxLast);
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CmdTick) begin
            state_d = StRead;
          end else if (in_data_i.cmd > CmdQuery) begin
            state_d = StIdle;
          end else if (in_oor) begin
            state_d = StFin;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: state_d = StPrep;
      StPrep: state_d = StDiv;
      StDiv: begin
        if (cnt_q == 3'd7) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = tick_more ? StRead : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: strobes.
  // ---------------------------------------------------------------------
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      StIdle: ctrl.in_ready = 1'b1;
      StRead: ctrl.rd_en = 1'b1;
      StPrep: ctrl.lane_init = 1'b1;
      StDiv:  ctrl.lane_step = 1'b1;
      StFin:  ctrl.fin_go = out_free;
      default: ctrl = '0;
    endcase
  end

  assign in_ready_o = ctrl.in_ready;
  assign mem_we = ctrl.fin_go && !oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      cnt_q       <= '0;
      oor_q       <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && ctrl.in_ready) begin
        idx_q <= (in_data_i.cmd == CmdTick) ? '0 : IdxW'(in_data_i.group);
        oor_q <= in_oor && (in_data_i.cmd != CmdTick);
      end else if (ctrl.fin_go && tick_more) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl.lane_init) begin
        cnt_q <= '0;
      end else if (ctrl.lane_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (mem_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (ctrl.fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Fader memory. A fader never written since reset reads as its reset
  // value. Reads and the write of one fader fall in different cycles, so
  // no forwarding is needed.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= wr_ent;
    end
    if (ctrl.rd_en) begin
      rd_q     <= mem_q[idx_q];
      rd_vld_q <= vld_q[idx_q];
    end
    if (in_valid_i && ctrl.in_ready) begin
      cur_q <= in_data_i;
    end
  end

  assign ent = rd_vld_q ? rd_q : FaderReset;

  // ---------------------------------------------------------------------
  // Blend: four lanes each form start*(D-E) + target*E + D/2 and divide it
  // by D one quotient bit per cycle. The quotient always fits in 8 bits,
  // so the upper numerator bits start out below D.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ctrl.lane_init) begin
      bypass_q <= (ent.fade_length == '0) || (ent.time_spent >= ent.fade_length);
      for (int l = 0; l < 4; l++) begin
        logic [NumW-1:0] num;
        logic [TimeBits-1:0] rest;
        rest = (ent.time_spent >= ent.fade_length) ? '0
               : ent.fade_length - ent.time_spent;
        num = NumW'(ent.start_color[l*8 +: 8]) * NumW'(rest)
            + NumW'(ent.target_color[l*8 +: 8]) * NumW'(ent.time_spent)
            + NumW'(ent.fade_length >> 1);
        lane_q[l].rem <= num[NumW-1:ChanW];
        lane_q[l].qn  <= num[ChanW-1:0];
      end
    end else if (ctrl.lane_step) begin
      for (int l = 0; l < 4; l++) begin
        logic [TimeBits:0] trial;
        trial = {lane_q[l].rem, lane_q[l].qn[ChanW-1]};
        if (trial >= {1'b0, ent.fade_length}) begin
          lane_q[l].rem <= TimeBits'(trial - {1'b0, ent.fade_length});
          lane_q[l].qn  <= {lane_q[l].qn[ChanW-2:0], 1'b1};
        end else begin
          lane_q[l].rem <= trial[TimeBits-1:0];
          lane_q[l].qn  <= {lane_q[l].qn[ChanW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Write-back: the command's update of the fader and its result beat.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [31:0]         blend;
    logic [31:0]         rgb;
    logic [TicketW-1:0]  tkt;
    logic [32:0]         sum;
    blend = bypass_q ? ent.target_color
          : {lane_q[3].qn, lane_q[2].qn, lane_q[1].qn, lane_q[0].qn};
    rgb   = {8'h00, cur_q.blue, cur_q.green, cur_q.red};
    tkt   = ent.fade_ticket + 1'b1;
    if (tkt == '0) begin
      tkt = TicketW'(1);
    end
    // Elapsed time saturates at the widest count that the time field holds.
    sum   = 33'(ent.time_spent) + 33'(cur_q.elapsed_step);
    wr_ent = ent;
    res    = '0;
    res.fader_index = 3'(idx_q);
    res.last = 1'b1;
    unique case (cur_q.cmd)
      CmdTick: begin
        if (ent.active_flag) begin
          if (ent.time_spent >= ent.fade_length) begin
            if (ent.fading_in) begin
              wr_ent.active_flag = 1'b0;
            end
            wr_ent.start_color = ent.target_color;
            wr_ent.fade_ticket = '0;
          end
          wr_ent.drawn_color = blend;
          wr_ent.time_spent  = (sum > 33'(TimeMax)) ? TimeMax : TimeBits'(sum);
        end
        {res.out_alpha, res.out_blue, res.out_green, res.out_red} =
          wr_ent.drawn_color;
        res.is_active = wr_ent.active_flag;
        res.last = (idx_q == IdxLast);
      end
      CmdFadeIn, CmdFadeOut: begin
        if (ent.fade_ticket == '0 || !cur_q.use_current) begin
          wr_ent.start_color = rgb | ((cur_q.cmd == CmdFadeIn) ? 32'hFF00_0000 : 32'h0);
        end else begin
          wr_ent.start_color = blend;
        end
        wr_ent.target_color = rgb | ((cur_q.cmd == CmdFadeIn) ? 32'h0 : 32'hFF00_0000);
        // A length beyond the time field saturates to its maximum.
        wr_ent.fade_length  = (32'(cur_q.fade_ticks) > 32'(TimeMax)) ? TimeMax
                              : TimeBits'(cur_q.fade_ticks);
        wr_ent.time_spent   = '0;
        wr_ent.fading_in    = (cur_q.cmd == CmdFadeIn);
        wr_ent.active_flag  = 1'b1;
        wr_ent.fade_ticket  = tkt;
        // With no time spent the blend is the start color, or the target
        // for an immediate fade.
        {res.out_alpha, res.out_blue, res.out_green, res.out_red} =
          (wr_ent.fade_length == '0) ? wr_ent.target_color : wr_ent.start_color;
        res.is_active  = 1'b1;
        res.new_ticket = tkt;
      end
      CmdStop: begin
        wr_ent.active_flag = 1'b0;
        {res.out_alpha, res.out_blue, res.out_green, res.out_red} = blend;
      end
      CmdQuery: begin
        {res.out_alpha, res.out_blue, res.out_green, res.out_red} = blend;
        res.is_active  = ent.active_flag;
        res.is_playing = (cur_q.query_ticket != '0) &&
                         (cur_q.query_ticket == ent.fade_ticket);
      end
      default: begin
        wr_ent = ent;
      end
    endcase
    if (oor_q) begin
      res = '0;
      res.fader_index = cur_q.group;
      res.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fin_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `MCF_ASSERT(a_div_len, clk_i, rst_ni, (state_q == StDiv && cnt_q == 3'd7) |=> state_q == StFin)
  `MCF_NEVER(a_no_overwrite, clk_i, rst_ni, ctrl.fin_go && out_valid_q && !out_ready_i)
  `MCF_ASSERT(a_walk_tick, clk_i, rst_ni, (state_q == StRead && $past(state_q) == StFin) |-> is_tick)
  `MCF_ASSERT(a_last_idle, clk_i, rst_ni, (ctrl.fin_go && res.last) |=> state_q == StIdle)

endmodule
